@@ rtl/core/srqc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srqc_pkg
// Types, character codes, keyword spellings and byte helpers shared by the
// query route classifier.
// ----------------------------------------------------------------------------
package srqc_pkg;

   // window of the newest bytes: the current byte plus the cell chain
   localparam int WIN         = 8;
   localparam int CHAIN_DEPTH = WIN - 1;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   typedef logic [WIN-1:0][7:0] window_type;
   typedef logic [WIN-1:0][7:0] keyword_type;

   // spellings are written back to front so that index 0 holds the first letter
   localparam keyword_type KW_GROUP  = "YB PUORG";
   localparam keyword_type KW_COUNT  = "TNUOC";
   localparam keyword_type KW_SUM    = "MUS";
   localparam keyword_type KW_AVG    = "GVA";
   localparam keyword_type KW_MIN    = "NIM";
   localparam keyword_type KW_MAX    = "XAM";
   localparam keyword_type KW_SELECT = "TCELES";

   localparam int LEN_GROUP  = 8;
   localparam int LEN_COUNT  = 5;
   localparam int LEN_THREE  = 3;
   localparam int LEN_SELECT = 6;

   typedef struct packed {
      logic pending_hit;   // short aggregate keyword ends at this byte
      logic group_hit;     // group by ends at this byte
   } hit_type;

   typedef struct packed {
      logic sel;
      logic agg;
   } verdict_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_break(input logic [7:0] c);
      return is_ws(c) || c == CH_LPAREN || c == CH_COMMA;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
   endfunction

   // keyword of length len ends at window slot 0 and starts at a word start
   function automatic logic kw_hit(input window_type w, input logic [WIN-1:0] c,
                                   input keyword_type kw, input int len);
      logic hit;
      hit = c[3'(len - 1)];
      for (int j = 0; j < WIN; j++) begin
         if (j < len && w[3'(len - 1 - j)] != kw[j]) hit = 1'b0;
      end
      return hit;
   endfunction

endpackage

@@ rtl/core/srqc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srqc_cell
// One stage of the byte history chain: a case-folded byte and its word-start
// bit, handed on to the next stage on a transfer, cleared by a query's last byte.
// ----------------------------------------------------------------------------
module srqc_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift,
   input  logic       flush,
   input  logic [7:0] prev_byte,
   input  logic       prev_cand,
   output logic [7:0] byte_out,
   output logic       cand_out
);

   logic [7:0] byte_ff, byte_in;
   logic       cand_ff, cand_in;

   always_comb begin
      byte_in = byte_ff;
      cand_in = cand_ff;
      if (flush) begin
         byte_in = '0;
         cand_in = 1'b0;
      end else if (shift) begin
         byte_in = prev_byte;
         cand_in = prev_cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
         cand_ff <= 1'b0;
      end else begin
         byte_ff <= byte_in;
         cand_ff <= cand_in;
      end
   end

   assign byte_out = byte_ff;
   assign cand_out = cand_ff;

endmodule

@@ rtl/core/srqc_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srqc_scan
// Per-query tracking: quote state, SELECT prefix recognizer, pending short
// keyword and the aggregate flag. Gives the word-start bit of each byte.
// ----------------------------------------------------------------------------
module srqc_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 xfer,
   input  logic                 last,
   input  logic [7:0]           cur_byte,
   input  logic [7:0]           prev_byte,
   input  srqc_pkg::hit_type    hits,
   output logic                 cand,
   output srqc_pkg::verdict_type verdict
);

   typedef enum logic [2:0] {
      QM_NORMAL, QM_SQ, QM_SQ_ESC, QM_DQ, QM_DQ_ESC, QM_BT
   } quote_type;

   typedef enum logic [1:0] {
      SP_SKIP, SP_MATCH, SP_FOLLOW, SP_DONE
   } phase_type;

   quote_type  quote_ff, quote_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] prog_ff, prog_in;
   logic       pending_ff, pending_in;
   logic       agg_ff, agg_in;
   logic       first_ff, first_in;

   logic       normal, follower;
   logic [7:0] up_byte;
   quote_type  quote_next;
   phase_type  phase_next;
   logic [2:0] prog_next;
   logic       agg_next;

   always_comb begin
      up_byte  = srqc_pkg::to_upper(cur_byte);
      follower = srqc_pkg::is_ws(cur_byte) || cur_byte == srqc_pkg::CH_LPAREN;
      normal   = !(quote_ff == QM_SQ || quote_ff == QM_SQ_ESC || quote_ff == QM_DQ ||
                   quote_ff == QM_DQ_ESC || quote_ff == QM_BT);
      cand = normal && cur_byte != srqc_pkg::CH_SQUOTE &&
             cur_byte != srqc_pkg::CH_DQUOTE && cur_byte != srqc_pkg::CH_BTICK &&
             (first_ff || srqc_pkg::is_break(prev_byte));

      quote_next = quote_ff;
      unique case (quote_ff)
         QM_SQ: begin
            if (cur_byte == srqc_pkg::CH_SQUOTE) quote_next = QM_NORMAL;
            else if (cur_byte == srqc_pkg::CH_BSLASH) quote_next = QM_SQ_ESC;
         end
         QM_DQ: begin
            if (cur_byte == srqc_pkg::CH_DQUOTE) quote_next = QM_NORMAL;
            else if (cur_byte == srqc_pkg::CH_BSLASH) quote_next = QM_DQ_ESC;
         end
         QM_SQ_ESC: quote_next = QM_SQ;
         QM_DQ_ESC: quote_next = QM_DQ;
         QM_BT: begin
            if (cur_byte == srqc_pkg::CH_BTICK) quote_next = QM_NORMAL;
         end
         default: begin
            // normal, and the unused codes that behave as normal
            priority if (cur_byte == srqc_pkg::CH_SQUOTE) quote_next = QM_SQ;
            else if (cur_byte == srqc_pkg::CH_DQUOTE) quote_next = QM_DQ;
            else if (cur_byte == srqc_pkg::CH_BTICK) quote_next = QM_BT;
            else quote_next = QM_NORMAL;
         end
      endcase

      phase_next = phase_ff;
      prog_next  = prog_ff;
      unique case (phase_ff)
         SP_SKIP: begin
            if (!srqc_pkg::is_ws(cur_byte)) begin
               if (up_byte == srqc_pkg::KW_SELECT[0]) begin
                  phase_next = SP_MATCH;
                  prog_next  = 3'd1;
               end else begin
                  phase_next = SP_DONE;
                  prog_next  = 3'd0;
               end
            end
         end
         SP_MATCH: begin
            if (up_byte == srqc_pkg::KW_SELECT[prog_ff]) begin
               prog_next = prog_ff + 3'd1;
               if (prog_ff == 3'(srqc_pkg::LEN_SELECT - 1)) phase_next = SP_FOLLOW;
            end else begin
               phase_next = SP_DONE;
               prog_next  = 3'd0;
            end
         end
         SP_FOLLOW: begin
            // verdict kept in the progress count once decided
            phase_next = SP_DONE;
            prog_next  = follower ? 3'd1 : 3'd0;
         end
         default: ;
      endcase

      agg_next = agg_ff || (pending_ff && follower) || hits.group_hit ||
                 (last && hits.pending_hit);

      verdict.sel = phase_next == SP_FOLLOW || (phase_next == SP_DONE && prog_next == 3'd1);
      verdict.agg = agg_next;

      quote_in   = quote_ff;
      phase_in   = phase_ff;
      prog_in    = prog_ff;
      pending_in = pending_ff;
      agg_in     = agg_ff;
      first_in   = first_ff;
      if (xfer) begin
         if (last) begin
            quote_in   = QM_NORMAL;
            phase_in   = SP_SKIP;
            prog_in    = 3'd0;
            pending_in = 1'b0;
            agg_in     = 1'b0;
            first_in   = 1'b1;
         end else begin
            quote_in   = quote_next;
            phase_in   = phase_next;
            prog_in    = prog_next;
            pending_in = hits.pending_hit;
            agg_in     = agg_next;
            first_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff   <= QM_NORMAL;
         phase_ff   <= SP_SKIP;
         prog_ff    <= 3'd0;
         pending_ff <= 1'b0;
         agg_ff     <= 1'b0;
         first_ff   <= 1'b1;
      end else begin
         quote_ff   <= quote_in;
         phase_ff   <= phase_in;
         prog_ff    <= prog_in;
         pending_ff <= pending_in;
         agg_ff     <= agg_in;
         first_ff   <= first_in;
      end
   end

   a_new_query_starts_clean: assert property (@(posedge clock) disable iff (reset)
      xfer && last |=> first_ff && quote_ff == QM_NORMAL && phase_ff == SP_SKIP && !agg_ff)
      else $error("scan state not cleared after last byte");

   a_first_cleared: assert property (@(posedge clock) disable iff (reset)
      xfer && !last |=> !first_ff)
      else $error("first byte flag held after a middle byte");

   a_match_progress: assert property (@(posedge clock) disable iff (reset)
      phase_ff == SP_MATCH |-> prog_ff >= 3'd1 && prog_ff <= 3'd5)
      else $error("select progress out of range while matching");

endmodule

@@ rtl/core/sql_query_route_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_query_route_classifier
// Classifies one SQL query text, byte by byte, for routing to an aggregate
// engine.
// ----------------------------------------------------------------------------
// The block takes one query byte per clock cycle while not stalled, with no
// gaps needed between bytes or between queries. The last byte of a query yields
// one result in the result register on the next cycle; other bytes yield none.
// The input is stalled only during reset or while that result register is full
// and not being taken. The newest bytes sit in a chain of seven cells that
// shifts on every transfer and clears on a query's last byte. Keyword checks look
// at the chain plus the incoming byte, so a byte's whole decision completes in its cycle.
module sql_query_route_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_query_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_starts_with_select,
   output logic       rsp_may_aggregate,
   output logic       rsp_route_to_engine
);

   logic                  xfer, flush, cand;
   logic [srqc_pkg::WIN-1:0][7:0] link_byte;
   logic [srqc_pkg::WIN-1:0]      link_cand;
   srqc_pkg::window_type  win;
   srqc_pkg::hit_type     hits;
   srqc_pkg::verdict_type verdict;

   logic rsp_valid_ff, rsp_valid_in;
   logic sel_ff, sel_in, agg_ff, agg_in, route_ff, route_in;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign xfer      = req_valid && req_ready;
   assign flush     = xfer && req_last_byte;

   // slot 0 of the window is the incoming byte
   assign link_byte[0] = srqc_pkg::to_upper(req_query_byte);
   assign link_cand[0] = cand;

   for (genvar i = 0; i < srqc_pkg::CHAIN_DEPTH; i++) begin : g_chain
      srqc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (xfer),
         .flush     (flush),
         .prev_byte (link_byte[i]),
         .prev_cand (link_cand[i]),
         .byte_out  (link_byte[i+1]),
         .cand_out  (link_cand[i+1])
      );
   end

   assign win = link_byte;

   always_comb begin
      hits.group_hit = srqc_pkg::kw_hit(win, link_cand, srqc_pkg::KW_GROUP,
                                        srqc_pkg::LEN_GROUP);
      hits.pending_hit =
         srqc_pkg::kw_hit(win, link_cand, srqc_pkg::KW_COUNT, srqc_pkg::LEN_COUNT) ||
         srqc_pkg::kw_hit(win, link_cand, srqc_pkg::KW_SUM, srqc_pkg::LEN_THREE) ||
         srqc_pkg::kw_hit(win, link_cand, srqc_pkg::KW_AVG, srqc_pkg::LEN_THREE) ||
         srqc_pkg::kw_hit(win, link_cand, srqc_pkg::KW_MIN, srqc_pkg::LEN_THREE) ||
         srqc_pkg::kw_hit(win, link_cand, srqc_pkg::KW_MAX, srqc_pkg::LEN_THREE);
   end

   srqc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .xfer      (xfer),
      .last      (req_last_byte),
      .cur_byte  (req_query_byte),
      .prev_byte (link_byte[1]),
      .hits      (hits),
      .cand      (cand),
      .verdict   (verdict)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      sel_in       = sel_ff;
      agg_in       = agg_ff;
      route_in     = route_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (flush) begin
         rsp_valid_in = 1'b1;
         sel_in       = verdict.sel;
         agg_in       = verdict.agg;
         route_in     = verdict.sel && verdict.agg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      sel_ff   <= sel_in;
      agg_ff   <= agg_in;
      route_ff <= route_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_starts_with_select = sel_ff;
   assign rsp_may_aggregate      = agg_ff;
   assign rsp_route_to_engine    = route_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      flush |=> rsp_valid_ff)
      else $error("no result after last byte");

   a_chain_flushed: assert property (@(posedge clock) disable iff (reset)
      flush |=> link_cand[srqc_pkg::WIN-1:1] == '0)
      else $error("byte chain not cleared between queries");

   a_route_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> route_ff == (sel_ff && agg_ff))
      else $error("route flag disagrees with the two flags");

endmodule
